/* hdl/kfli_pkg.sv */
package kfli_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int FACTOR_BITS  = 30;
  localparam int FACTOR_W     = FACTOR_BITS + 1;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCHK,
    ST_RD0,
    ST_RD1,
    ST_CALC,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  key_index;
    logic [31:0] key_time;
    logic [31:0] value_x;
    logic [31:0] value_y;
    logic [31:0] value_z;
    logic [31:0] sample_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [5:0]  segment;
    logic        clamped;
  } out_item_t;

  typedef struct packed {
    logic                   valid;
    logic [31:0]            rem;
    logic [31:0]            den;
    logic [FACTOR_BITS-1:0] quo;
  } div_stage_t;

endpackage

/* hdl/keyframe_linear_interpolator_core.sv */
// A load item is taken in the IDLE state. A sample item steps through SCAN and SCHK
// for each key scanned, then RD0, RD1 and CALC to fetch both keys and set up, then
// the divider chain when a division is needed, then MUL and FIN to scale and round.
// Only one item is in flight at a time: in_stall is high until the block is back in IDLE.
// Synchronous active-high reset clears control state and sets key_count to 1;
// the key table is not cleared.
module keyframe_linear_interpolator_core #(
  parameter int MAX_KEYS = kfli_pkg::MAX_KEYS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  kfli_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kfli_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int FB = kfli_pkg::FACTOR_BITS;
  localparam int FW = kfli_pkg::FACTOR_W;

  kfli_pkg::state_t state, state_next;

  logic [6:0]    key_count;
  logic [CW-1:0] n;
  logic [AW-1:0] idx;
  logic [AW-1:0] seg;
  logic [AW-1:0] rd_addr;
  logic [31:0]   t;
  logic          single;
  logic [127:0]  mem [MAX_KEYS];
  logic [127:0]  rdata;
  logic          in_acc;
  logic          load_ok;

  logic [31:0] t0, x0, y0, z0, x1, y1, z1;
  logic [31:0] t1, num, den;
  logic [FW-1:0] factor;
  logic          clamped;
  logic          need_div;
  logic          last_key;

  logic [63:0] prod_x, prod_y, prod_z;
  logic        neg_x, neg_y, neg_z;

  kfli_pkg::div_stage_t st [FB+1];

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign load_ok   = 32'(in_data.key_index) < MAX_KEYS;
  assign t1        = rdata[127:96];
  assign num       = t - t0;
  assign den       = t1 - t0;
  assign need_div  = !single && (t1 > t0) && (t >= t0) && (num < den);
  assign last_key  = (32'(idx) + 2) == 32'(n);

  always_comb begin
    if (key_count == 7'd0) begin
      n = CW'(1);
    end else if (32'(key_count) > MAX_KEYS) begin
      n = CW'(MAX_KEYS);
    end else begin
      n = CW'(key_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      key_count <= cfg_data;
    end
  end

  // key table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && in_data.kind == kfli_pkg::KIND_LOAD && load_ok) begin
      mem[AW'(in_data.key_index)] <= {in_data.key_time, in_data.value_x,
                                      in_data.value_y, in_data.value_z};
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      kfli_pkg::ST_IDLE: begin
        if (in_acc && in_data.kind == kfli_pkg::KIND_SAMPLE) begin
          state_next = (n == CW'(1)) ? kfli_pkg::ST_RD0 : kfli_pkg::ST_SCAN;
        end
      end
      kfli_pkg::ST_SCAN: state_next = kfli_pkg::ST_SCHK;
      kfli_pkg::ST_SCHK: begin
        if (t < t1 || last_key) begin
          state_next = kfli_pkg::ST_RD0;
        end else begin
          state_next = kfli_pkg::ST_SCAN;
        end
      end
      kfli_pkg::ST_RD0:  state_next = kfli_pkg::ST_RD1;
      kfli_pkg::ST_RD1:  state_next = kfli_pkg::ST_CALC;
      kfli_pkg::ST_CALC: state_next = need_div ? kfli_pkg::ST_DIV : kfli_pkg::ST_MUL;
      kfli_pkg::ST_DIV:  state_next = st[FB].valid ? kfli_pkg::ST_MUL : kfli_pkg::ST_DIV;
      kfli_pkg::ST_MUL:  state_next = kfli_pkg::ST_FIN;
      kfli_pkg::ST_FIN: begin
        if (!out_valid || !out_stall) begin
          state_next = kfli_pkg::ST_IDLE;
        end
      end
      default: state_next = kfli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != kfli_pkg::ST_IDLE);
    case (state)
      kfli_pkg::ST_SCAN: rd_addr = idx + AW'(1);
      kfli_pkg::ST_RD0:  rd_addr = seg;
      kfli_pkg::ST_RD1:  rd_addr = single ? seg : seg + AW'(1);
      default:           rd_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kfli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      kfli_pkg::ST_IDLE: begin
        t      <= in_data.sample_time;
        single <= (n == CW'(1));
        idx    <= '0;
        seg    <= '0;
      end
      kfli_pkg::ST_SCHK: begin
        seg <= idx;
        idx <= idx + AW'(1);
      end
      kfli_pkg::ST_RD1: begin
        t0 <= rdata[127:96];
        x0 <= rdata[95:64];
        y0 <= rdata[63:32];
        z0 <= rdata[31:0];
      end
      kfli_pkg::ST_CALC: begin
        x1 <= single ? x0 : rdata[95:64];
        y1 <= single ? y0 : rdata[63:32];
        z1 <= single ? z0 : rdata[31:0];
        if (single) begin
          factor  <= '0;
          clamped <= 1'b0;
        end else if (t1 <= t0 || t < t0) begin
          factor  <= '0;
          clamped <= 1'b1;
        end else if (num > den) begin
          factor  <= FW'(1) << FB;
          clamped <= 1'b1;
        end else begin
          factor  <= FW'(1) << FB;
          clamped <= 1'b0;
        end
      end
      kfli_pkg::ST_DIV: begin
        if (st[FB].valid) begin
          factor <= {1'b0, st[FB].quo};
        end
      end
      default: begin
      end
    endcase
  end

  // divider chain: one quotient bit per cell
  always_comb begin
    st[0].valid = (state == kfli_pkg::ST_CALC) && need_div;
    st[0].rem   = num;
    st[0].den   = den;
    st[0].quo   = '0;
  end

  for (genvar k = 0; k < FB; k++) begin : g_div
    kfli_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (st[k]),
      .dout (st[k+1])
    );
  end

  // scale: |delta| is up to 33 bits, split off its top bit to keep a 32x31 multiply
  function automatic logic [64:0] scale(input logic [31:0] a, input logic [31:0] b,
                                        input logic [FW-1:0] f);
    logic [32:0] delta;
    logic [32:0] mag;
    logic [63:0] p;
    begin
      delta = {b[31], b} - {a[31], a};
      mag   = delta[32] ? (33'd0 - delta) : delta;
      p     = (64'(mag[31:0]) * 64'(f)) + (mag[32] ? (64'(f) << 32) : 64'd0);
      scale = {delta[32], p};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (state == kfli_pkg::ST_MUL) begin
      {neg_x, prod_x} <= scale(x0, x1, factor);
      {neg_y, prod_y} <= scale(y0, y1, factor);
      {neg_z, prod_z} <= scale(z0, z1, factor);
    end
  end

  function automatic logic [31:0] finish(input logic [31:0] a, input logic [63:0] p,
                                         input logic neg);
    logic [63:0] r;
    begin
      r      = (p + (64'd1 << (FB - 1))) >> FB;
      finish = neg ? (a - r[31:0]) : (a + r[31:0]);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == kfli_pkg::ST_FIN && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (state == kfli_pkg::ST_FIN && (!out_valid || !out_stall)) begin
      out_data.out_x   <= finish(x0, prod_x, neg_x);
      out_data.out_y   <= finish(y0, prod_y, neg_y);
      out_data.out_z   <= finish(z0, prod_z, neg_z);
      out_data.segment <= 6'(seg);
      out_data.clamped <= clamped;
    end
  end

endmodule

/* hdl/kfli_div_cell.sv */
module kfli_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  kfli_pkg::div_stage_t din,
  output kfli_pkg::div_stage_t dout
);

  logic [32:0] rem2;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] rem_next;

  // one restoring step: shift the remainder, subtract when it fits
  always_comb begin
    rem2     = {din.rem, 1'b0};
    diff     = rem2 - {1'b0, din.den};
    ge       = rem2 >= {1'b0, din.den};
    rem_next = ge ? diff[31:0] : rem2[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.rem <= rem_next;
    dout.den <= din.den;
    dout.quo <= {din.quo[kfli_pkg::FACTOR_BITS-2:0], ge};
  end

endmodule
